// ===== rtl/core/psnc_pkg.sv =====
// Package for the palette store with nearest-color search.
// Holds the command and result word types, opcodes, sequencer states and shared constants.
// No dependencies.
`default_nettype none

package psnc_pkg;

	localparam int DEF_PALETTE_ENTRIES = 256;
	localparam int DIST_BITS           = 18;

	localparam logic [7:0] ALPHA_OPAQUE  = 8'hFF;
	localparam logic [7:0] DAC_KEEP_MASK = 8'hFC;

	typedef enum logic [1:0] {
		OP_WRITE   = 2'd0,
		OP_CONVERT = 2'd1,
		OP_SEARCH  = 2'd2,
		OP_NOP     = 2'd3
	} psnc_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SCAN
	} psnc_state_t;

	typedef struct packed {
		psnc_op_t   opcode;
		logic [7:0] entry_index;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} psnc_cmd_t;

	typedef struct packed {
		logic [31:0] color_word;
		logic [7:0]  nearest_index;
	} psnc_res_t;

	typedef struct packed {
		logic        we;
		logic [7:0]  waddr;
		logic [23:0] wdata;
		logic        re;
		logic [7:0]  raddr;
	} psnc_mem_req_t;

endpackage

`default_nettype wire

// ===== rtl/core/psnc_mem.sv =====
// Palette memory: one write port, one registered read port, per-entry valid bits.
// An entry never written reads as zero. Depends on psnc_pkg.
`default_nettype none

module psnc_mem import psnc_pkg::*; #(
	parameter int PALETTE_ENTRIES = DEF_PALETTE_ENTRIES
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire psnc_mem_req_t req,
	output logic [23:0]        rdata
);

	localparam int IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

	logic [23:0]                mem [PALETTE_ENTRIES];
	logic [PALETTE_ENTRIES-1:0] valid_q;
	logic [23:0]                data_q;
	logic                       vld_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr[IDX_W-1:0]] <= req.wdata;
		end
		if (req.re) begin
			data_q <= mem[req.raddr[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vld_q   <= 1'b0;
		end else begin
			if (req.we) begin
				valid_q[req.waddr[IDX_W-1:0]] <= 1'b1;
			end
			if (req.re) begin
				vld_q <= valid_q[req.raddr[IDX_W-1:0]];
			end
		end
	end

	assign rdata = vld_q ? data_q : 24'h0;

endmodule

`default_nettype wire

// ===== rtl/core/psnc_dist.sv =====
// Shared distance unit: squared differences of three components, registered, then summed.
// One palette entry per cycle. Depends on psnc_pkg.
`default_nettype none

module psnc_dist import psnc_pkg::*; (
	input  wire logic [23:0]      entry,
	input  wire logic             clk,
	input  wire logic [23:0]      target,
	output logic [DIST_BITS-1:0]  sq_dist
);

	function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] d;
		d = (a > b) ? (a - b) : (b - a);
		return 16'(d) * 16'(d);
	endfunction

	logic [15:0] sq_r_s2;
	logic [15:0] sq_g_s2;
	logic [15:0] sq_b_s2;

	always_ff @(posedge clk) begin
		sq_r_s2 <= sq_diff(target[23:16], entry[23:16]);
		sq_g_s2 <= sq_diff(target[15:8],  entry[15:8]);
		sq_b_s2 <= sq_diff(target[7:0],   entry[7:0]);
	end

	assign sq_dist = DIST_BITS'(sq_r_s2) + DIST_BITS'(sq_g_s2) + DIST_BITS'(sq_b_s2);

endmodule

`default_nettype wire

// ===== rtl/core/psnc_ctrl.sv =====
// Sequencer: takes commands, drives the palette memory port, walks the search one entry a cycle
// and keeps the best match. Depends on psnc_pkg.
`default_nettype none

module psnc_ctrl import psnc_pkg::*; #(
	parameter int PALETTE_ENTRIES = DEF_PALETTE_ENTRIES
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire psnc_cmd_t            cmd,
	output logic                      busy,
	output psnc_mem_req_t             mem_req,
	input  wire logic [23:0]          rdata,
	output logic [23:0]               target,
	input  wire logic [DIST_BITS-1:0] sq_dist,
	output logic                      done,
	output psnc_res_t                 result
);

	localparam int IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(PALETTE_ENTRIES - 1);
	localparam logic [8:0]       ENTRIES_LIM = 9'(PALETTE_ENTRIES);

	psnc_state_t state_q, state_d;

	logic [IDX_W-1:0]     scan_q;
	logic                 issue_q;
	logic                 v_s1, v_s2;
	logic [IDX_W-1:0]     idx_s1, idx_s2;
	logic [23:0]          tgt_q;
	logic                 oor_q;
	logic [DIST_BITS-1:0] best_q;
	logic [IDX_W-1:0]     best_idx_q;
	logic                 have_q;
	logic                 done_q;
	psnc_res_t            res_q;

	logic accept;
	logic in_range;
	logic better;
	logic finish;
	logic scanning;

	assign accept   = start && (state_q == ST_IDLE);
	assign in_range = {1'b0, cmd.entry_index} < ENTRIES_LIM;
	assign scanning = (state_q == ST_SCAN);
	assign better   = v_s2 && (!have_q || (sq_dist < best_q));
	// exact match ends the scan early; the answer is the same as a full pass
	assign finish   = v_s2 && ((better && (sq_dist == '0)) || (idx_s2 == LAST_IDX));

	always_comb begin
		state_d = state_q;
		mem_req = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (cmd.opcode)
						OP_WRITE: begin
							mem_req.we    = in_range;
							mem_req.waddr = cmd.entry_index;
							mem_req.wdata = {cmd.red & DAC_KEEP_MASK,
							                 cmd.green & DAC_KEEP_MASK,
							                 cmd.blue & DAC_KEEP_MASK};
						end
						OP_CONVERT: begin
							mem_req.re    = 1'b1;
							mem_req.raddr = cmd.entry_index;
							state_d       = ST_CONV;
						end
						OP_SEARCH: begin
							state_d = ST_SCAN;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_CONV: begin
				state_d = ST_IDLE;
			end
			ST_SCAN: begin
				mem_req.re    = issue_q;
				mem_req.raddr = 8'(scan_q);
				if (finish) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			issue_q <= 1'b0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			have_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_CONV) || (scanning && finish);
			v_s1    <= scanning && issue_q && !finish;
			v_s2    <= v_s1 && !finish;
			if (accept && (cmd.opcode == OP_SEARCH)) begin
				issue_q <= 1'b1;
			end else if (finish || (issue_q && (scan_q == LAST_IDX))) begin
				issue_q <= 1'b0;
			end
			if (accept) begin
				have_q <= 1'b0;
			end else if (scanning && better) begin
				have_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= scan_q;
		idx_s2 <= idx_s1;
		if (accept) begin
			scan_q <= '0;
			tgt_q  <= {cmd.red, cmd.green, cmd.blue};
			oor_q  <= !in_range;
		end else if (issue_q) begin
			scan_q <= scan_q + 1'b1;
		end
		if (scanning && better) begin
			best_q     <= sq_dist;
			best_idx_q <= idx_s2;
		end
		if (state_q == ST_CONV) begin
			res_q.color_word    <= {ALPHA_OPAQUE, oor_q ? 24'h0 : rdata};
			res_q.nearest_index <= 8'h0;
		end else if (scanning && finish) begin
			res_q.color_word    <= 32'h0;
			res_q.nearest_index <= better ? 8'(idx_s2) : 8'(best_idx_q);
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign target = tgt_q;
	assign done   = done_q;
	assign result = res_q;

endmodule

`default_nettype wire

// ===== rtl/core/palette_store_nearest_color_top.sv =====
// Palette store with nearest-color search: top level.
// Instantiates psnc_ctrl, psnc_mem and psnc_dist; depends on psnc_pkg.
//
// Usage:
//   Command channel: cmd is taken at a rising edge with start high and busy low.
//   Result channel: done is high for one cycle with the result word on result;
//   the receiver cannot hold it off, and a new command may be taken in that cycle.
//   Write: no result; low two bits of each component are dropped;
//     an index beyond the store is ignored.
//   Convert: result {FF,R,G,B}; busy until the result.
//   Search: one palette entry per cycle through the registered memory read port and
//     the shared distance unit; the scan stops at the first exact match, else after the
//     last entry; busy until the result.
//   Opcode 3: no effect, no result.
//   Reset: the sequencer goes idle and every palette entry reads as zero at once
//     (per-entry valid bits); no clearing pass.
`default_nettype none

module palette_store_nearest_color_top import psnc_pkg::*; #(
	parameter int PALETTE_ENTRIES = DEF_PALETTE_ENTRIES
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire psnc_cmd_t cmd,
	output logic           busy,
	output logic           done,
	output psnc_res_t      result
);

	psnc_mem_req_t        mem_req;
	logic [23:0]          rdata;
	logic [23:0]          target;
	logic [DIST_BITS-1:0] sq_dist;

	psnc_ctrl #(
		.PALETTE_ENTRIES(PALETTE_ENTRIES)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.mem_req(mem_req),
		.rdata  (rdata),
		.target (target),
		.sq_dist(sq_dist),
		.done   (done),
		.result (result)
	);

	psnc_mem #(
		.PALETTE_ENTRIES(PALETTE_ENTRIES)
	) u_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (mem_req),
		.rdata (rdata)
	);

	psnc_dist u_dist (
		.entry  (rdata),
		.clk    (clk),
		.target (target),
		.sq_dist(sq_dist)
	);

endmodule

`default_nettype wire

// ===== rtl/core/psnc_chk.sv =====
// Port-level checker for the palette store, bound to the top level.
// Depends on psnc_pkg.
`default_nettype none

module psnc_chk import psnc_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      start,
	input wire psnc_cmd_t cmd,
	input wire logic      busy,
	input wire logic      done,
	input wire psnc_res_t result
);

	// a result word is either a convert word or a search word, never a mix
	a_res_shape: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((result.color_word == 32'h0) ||
		          ((result.color_word[31:24] == ALPHA_OPAQUE) && (result.nearest_index == 8'h0))))
		else $error("result word mixes convert and search fields");

	a_conv_lat: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (cmd.opcode == OP_CONVERT)) |=> busy ##1 (done && !busy))
		else $error("convert result not delivered on time");

	a_no_res: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && ((cmd.opcode == OP_WRITE) || (cmd.opcode == OP_NOP))) |=> !done)
		else $error("write or no-op produced a result");

	a_busy_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

endmodule

bind palette_store_nearest_color_top psnc_chk u_psnc_chk (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.cmd   (cmd),
	.busy  (busy),
	.done  (done),
	.result(result)
);

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for palette_store_nearest_color_top: directed then random commands,
// checked against a shadow palette and a closest-color search kept in the bench.
// Depends on psnc_pkg and the RTL under rtl/core.

import psnc_pkg::*;

class palette_shadow;
	logic [23:0] palette [DEF_PALETTE_ENTRIES];
	psnc_res_t   lookups_due [$];
	int errors, checked;
	int n_write, n_conv, n_search, n_exact, n_nop;

	function new();
		foreach (palette[i]) palette[i] = '0;
	endfunction

	function int pending();
		return lookups_due.size();
	endfunction

	// lowest index at the least squared distance, stopping at the first exact hit
	function logic [7:0] find_closest(logic [7:0] r, logic [7:0] g, logic [7:0] b,
			output bit exact);
		int best_d, d, dr, dg, db;
		logic [7:0] best;
		best = '0;
		best_d = 0;
		for (int i = 0; i < DEF_PALETTE_ENTRIES; i++) begin
			dr = int'(r) - int'(palette[i][23:16]);
			dg = int'(g) - int'(palette[i][15:8]);
			db = int'(b) - int'(palette[i][7:0]);
			d = dr * dr + dg * dg + db * db;
			if (i == 0 || d < best_d) begin
				best = 8'(i);
				best_d = d;
				if (d == 0)
					break;
			end
		end
		exact = (best_d == 0);
		return best;
	endfunction

	function void take_cmd(psnc_cmd_t c);
		psnc_res_t w;
		bit hit;
		case (c.opcode)
			OP_WRITE: begin
				n_write++;
				if (int'(c.entry_index) < DEF_PALETTE_ENTRIES)
					palette[c.entry_index] = {c.red & DAC_KEEP_MASK,
						c.green & DAC_KEEP_MASK, c.blue & DAC_KEEP_MASK};
			end
			OP_CONVERT: begin
				n_conv++;
				w.nearest_index = '0;
				w.color_word = {ALPHA_OPAQUE, 24'h0};
				if (int'(c.entry_index) < DEF_PALETTE_ENTRIES)
					w.color_word[23:0] = palette[c.entry_index];
				lookups_due.push_back(w);
			end
			OP_SEARCH: begin
				n_search++;
				w.color_word = '0;
				w.nearest_index = find_closest(c.red, c.green, c.blue, hit);
				if (hit)
					n_exact++;
				lookups_due.push_back(w);
			end
			default: n_nop++;
		endcase
	endfunction

	task report(string what);
		$display("%0t mismatch: %s", $time, what);
		errors++;
	endtask

	task check_word(psnc_res_t got);
		psnc_res_t want;
		if (lookups_due.size() == 0) begin
			report($sformatf("result word %h with nothing outstanding", got));
			return;
		end
		want = lookups_due.pop_front();
		checked++;
		if (got.color_word !== want.color_word)
			report($sformatf("color_word %h, want %h", got.color_word, want.color_word));
		if (got.nearest_index !== want.nearest_index)
			report($sformatf("nearest_index %0d, want %0d",
				got.nearest_index, want.nearest_index));
	endtask
endclass

module tb;
	localparam int STALL_LIMIT = 4 * (DEF_PALETTE_ENTRIES + 8);

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      start = 1'b0;
	psnc_cmd_t cmd = '0;
	logic      busy, done;
	psnc_res_t result;
	int        quiet = 0;

	palette_shadow sb = new();

	palette_store_nearest_color_top #(.PALETTE_ENTRIES(DEF_PALETTE_ENTRIES)) dut (
		.clk, .arst_n, .start, .cmd, .busy, .done, .result
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.take_cmd(cmd);
			if (done)
				sb.check_word(result);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			quiet <= 0;
		else if (quiet >= STALL_LIMIT) begin
			$display("%0t no word moved for %0d cycles", $time, quiet);
			$display("[FAIL] regression broken");
			$finish;
		end else
			quiet <= quiet + 1;
	end

	function automatic psnc_cmd_t cmd_of(psnc_op_t op, logic [7:0] idx,
			logic [7:0] r, logic [7:0] g, logic [7:0] b);
		psnc_cmd_t c;
		c.opcode = op;
		c.entry_index = idx;
		c.red = r;
		c.green = g;
		c.blue = b;
		return c;
	endfunction

	function automatic psnc_cmd_t random_cmd();
		psnc_cmd_t c;
		logic [23:0] e;
		int pick;
		pick = $urandom_range(0, 99);
		c = cmd_of(OP_NOP, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		if (pick < 40) begin
			c.opcode = OP_WRITE;
			if ($urandom_range(0, 1) == 0)
				c.entry_index = 8'($urandom_range(0, 31));
		end else if (pick < 55)
			c.opcode = OP_CONVERT;
		else if (pick < 95) begin
			c.opcode = OP_SEARCH;
			e = sb.palette[$urandom_range(0, DEF_PALETTE_ENTRIES - 1)];
			case ($urandom_range(0, 2))
				0: {c.red, c.green, c.blue} = e;
				1: {c.red, c.green, c.blue} = e ^ {5'd0, 3'($urandom), 5'd0,
					3'($urandom), 5'd0, 3'($urandom)};
				default: ;
			endcase
		end
		return c;
	endfunction

	// start stays high across back-to-back words, so only one assignment per edge
	task automatic send(psnc_cmd_t c, int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy);
	endtask

	// outstanding count is read off the falling edge, clear of the monitor
	task automatic drain();
		start <= 1'b0;
		@(negedge clk);
		while (sb.pending() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	initial begin
		psnc_cmd_t c;
		int gap;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// cleared palette: everything reads zero, far search ties to entry 0
		send(cmd_of(OP_CONVERT, 8'd0, 8'h00, 8'h00, 8'h00), 0);
		send(cmd_of(OP_CONVERT, 8'd255, 8'hFF, 8'hFF, 8'hFF), 1);
		send(cmd_of(OP_SEARCH, 8'd0, 8'h00, 8'h00, 8'h00), 0);
		send(cmd_of(OP_SEARCH, 8'd255, 8'hFF, 8'hFF, 8'hFF), 2);
		send(cmd_of(OP_WRITE, 8'd0, 8'hFF, 8'hFF, 8'hFF), 0);
		send(cmd_of(OP_WRITE, 8'd255, 8'h03, 8'h03, 8'h03), 0);
		send(cmd_of(OP_WRITE, 8'd128, 8'hAA, 8'h55, 8'h0F), 0);
		send(cmd_of(OP_CONVERT, 8'd0, 8'h00, 8'h00, 8'h00), 0);
		send(cmd_of(OP_CONVERT, 8'd255, 8'h00, 8'h00, 8'h00), 0);
		send(cmd_of(OP_CONVERT, 8'd128, 8'h00, 8'h00, 8'h00), 3);
		send(cmd_of(OP_SEARCH, 8'd7, 8'hFF, 8'hFF, 8'hFF), 0);
		send(cmd_of(OP_SEARCH, 8'd0, 8'hFC, 8'hFC, 8'hFC), 0);
		send(cmd_of(OP_SEARCH, 8'd0, 8'hA8, 8'h54, 8'h0C), 0);
		send(cmd_of(OP_SEARCH, 8'd0, 8'h00, 8'h00, 8'h00), 0);
		// equal colors at 10 and 20: exact and off-by-two both pick 10
		send(cmd_of(OP_WRITE, 8'd10, 8'h80, 8'h80, 8'h80), 0);
		send(cmd_of(OP_WRITE, 8'd20, 8'h80, 8'h81, 8'h82), 0);
		send(cmd_of(OP_SEARCH, 8'd0, 8'h80, 8'h80, 8'h80), 1);
		send(cmd_of(OP_SEARCH, 8'd0, 8'h82, 8'h80, 8'h80), 0);
		send(cmd_of(OP_NOP, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 0);
		send(cmd_of(OP_NOP, 8'h00, 8'h00, 8'h00, 8'h00), 0);
		send(cmd_of(OP_WRITE, 8'd1, 8'h00, 8'hFF, 8'h00), 0);
		send(cmd_of(OP_SEARCH, 8'd0, 8'h01, 8'hFE, 8'h02), 0);
		send(cmd_of(OP_CONVERT, 8'd1, 8'hFF, 8'hFF, 8'hFF), 0);

		for (int n = 0; n < 600; n++) begin
			if (n == 300)
				drain();
			c = random_cmd();
			gap = ((n / 40) % 3 == 1) ? 0 : $urandom_range(0, 5);
			send(c, gap);
		end

		drain();
		repeat (DEF_PALETTE_ENTRIES + 8) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d result words never arrived", sb.pending()));

		$display("covered %0d writes, %0d converts, %0d searches (%0d exact hits), %0d nops",
			sb.n_write, sb.n_conv, sb.n_search, sb.n_exact, sb.n_nop);
		$display("%0d result words checked, %0d mismatches", sb.checked, sb.errors);
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

// ===== sim.f =====
rtl/core/psnc_pkg.sv
rtl/core/psnc_mem.sv
rtl/core/psnc_dist.sv
rtl/core/psnc_ctrl.sv
rtl/core/palette_store_nearest_color_top.sv
rtl/core/psnc_chk.sv
sim/tb.sv
